@@ rtl/flc_pkg.sv @@
`timescale 1ns / 1ps

package flc_pkg;

	// Fixed field widths
	localparam int COEF_W     = 16;
	localparam int COEF_IDX_W = 5;
	localparam int MODE_W     = 2;
	localparam int VALUE_W    = 16;
	localparam int OUT_W      = 38;
	localparam int NTAPS_W    = 6;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 40;

	// Input beat kinds carried on s_tuser
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} flc_state_t;

	// Commands broadcast to every cell of the row
	typedef struct packed {
		logic load;
		logic shift;
		logic rotate;
		logic clear;
	} cell_ctrl_t;

endpackage

@@ rtl/flc_cell.sv @@
`timescale 1ns / 1ps

module flc_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int INDEX       = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  flc_pkg::cell_ctrl_t                    ctrl,
	input  logic [flc_pkg::COEF_IDX_W-1:0]         coef_idx,
	input  logic signed [flc_pkg::COEF_W-1:0]      coef_in,
	input  logic signed [SAMPLE_BITS-1:0]          samp_prev,
	input  logic signed [flc_pkg::COEF_W-1:0]      coef_nxt,
	input  logic signed [SAMPLE_BITS-1:0]          samp_nxt,
	output logic signed [flc_pkg::COEF_W-1:0]      coef,
	output logic signed [SAMPLE_BITS-1:0]          samp
);
	import flc_pkg::*;

	localparam bit IN_RANGE = INDEX < (1 << COEF_IDX_W);

	logic                      hit;
	logic signed [COEF_W-1:0]  coef_q;
	logic signed [SAMPLE_BITS-1:0] samp_q;

	// Match the slot address against this cell's position
	assign hit = IN_RANGE && (coef_idx == COEF_IDX_W'(INDEX));

	// Load or pass the coefficient around the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (ctrl.load && hit) begin
			coef_q <= coef_in;
		end else if (ctrl.rotate) begin
			coef_q <= coef_nxt;
		end
	end

	// Clear, shift in from the lower-index neighbour, or pass around the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_q <= '0;
		end else if (ctrl.clear) begin
			samp_q <= '0;
		end else if (ctrl.shift) begin
			samp_q <= samp_prev;
		end else if (ctrl.rotate) begin
			samp_q <= samp_nxt;
		end
	end

	assign coef = coef_q;
	assign samp = samp_q;

endmodule

@@ rtl/flc_mac.sv @@
`timescale 1ns / 1ps

module flc_mac #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clr,
	input  logic                              en,
	input  logic signed [flc_pkg::COEF_W-1:0] coef,
	input  logic signed [SAMPLE_BITS-1:0]     samp,
	output logic signed [flc_pkg::OUT_W-1:0]  acc
);
	import flc_pkg::*;

	localparam int PROD_W = COEF_W + SAMPLE_BITS;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     en_s1;
	logic signed [OUT_W-1:0]  acc_q;

	// Register the product of the taps at the ring head
	always_ff @(posedge clk) begin
		prod_s1 <= coef * samp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= en;
		end
	end

	// Accumulate modulo 2^OUT_W; wrap matches the truncated exact sum
	always_ff @(posedge clk) begin
		if (clr) begin
			acc_q <= '0;
		end else if (en_s1) begin
			acc_q <= acc_q + OUT_W'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule

@@ rtl/fir_linear_convolution_top.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata {value, coef_index}, s_tuser mode
// m_*       out  m_tvalid/m_tready  m_tdata filtered_value, m_tlast last
// cfg_*     in   cfg_we             cfg_data num_taps
//
// A sample beat runs from accept to the next ready as one shift, a full turn
// of the cell ring past the single multiply-accumulate, one product drain and
// the load of the output register.
// A flush runs one pass fewer than the clamped tap count; each pass after the
// first shifts in its zero in the same cycle that loads the previous result.
// A load, an unused mode or a single tap flush completes in its accept cycle.
// The output register lets a new beat in while a result waits; a new result
// waits in the done state until that register is free.
// Reset clears coefficients, history and num_taps (to min(TAPS, 32)).

module fir_linear_convolution_top #(
	parameter int TAPS        = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [flc_pkg::NTAPS_W-1:0]      cfg_data,   // num_taps
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [flc_pkg::S_DATA_W-1:0]     s_tdata,    // coef_index[4:0], value[20:5]
	input  logic [flc_pkg::MODE_W-1:0]       s_tuser,    // mode[1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [flc_pkg::M_DATA_W-1:0]     m_tdata,    // filtered_value[37:0]
	output logic                             m_tlast
);
	import flc_pkg::*;

	localparam int N_W   = $clog2(TAPS + 1);
	localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam logic [NTAPS_W-1:0] NTAPS_RST = NTAPS_W'((TAPS < 32) ? TAPS : 32);

	flc_state_t state_q, state_nxt;
	cell_ctrl_t ctrl;

	logic [NTAPS_W-1:0]          num_taps_q;
	logic [N_W-1:0]              n_act;
	logic [IDX_W-1:0]            cnt_q;
	logic [N_W-1:0]              rem_q;
	logic                        flush_q;
	logic                        m_tvalid_q;
	logic [OUT_W-1:0]            m_data_q;
	logic                        m_last_q;

	logic                        accept;
	logic                        out_free;
	logic                        out_load;
	logic                        shift_zero;
	logic                        mac_clr;
	logic                        mac_en;
	logic                        cnt_last;
	logic                        single_tap;
	logic                        more_tail;

	logic [COEF_IDX_W-1:0]       s_idx;
	logic signed [VALUE_W-1:0]   s_value;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic signed [SAMPLE_BITS-1:0] shift_data;
	logic signed [OUT_W-1:0]     acc;

	logic signed [COEF_W-1:0]      coef_w [TAPS];
	logic signed [SAMPLE_BITS-1:0] samp_w [TAPS];

	// Unpack the input beat
	assign s_idx   = s_tdata[COEF_IDX_W-1:0];
	assign s_value = s_tdata[COEF_IDX_W+VALUE_W-1:COEF_IDX_W];

	generate
		if (SAMPLE_BITS <= VALUE_W) begin : g_samp_narrow
			assign in_sample = s_value[SAMPLE_BITS-1:0];
		end else begin : g_samp_wide
			assign in_sample = {{(SAMPLE_BITS-VALUE_W){1'b0}}, s_value};
		end
	endgenerate

	assign shift_data = shift_zero ? '0 : in_sample;

	// Clamp the tap count into 1..TAPS
	always_comb begin
		if (num_taps_q == '0) begin
			n_act = N_W'(1);
		end else if (32'(num_taps_q) > TAPS) begin
			n_act = N_W'(TAPS);
		end else begin
			n_act = N_W'(num_taps_q);
		end
	end

	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign cnt_last   = cnt_q == IDX_W'(TAPS - 1);
	assign single_tap = n_act == N_W'(1);
	assign more_tail  = flush_q && (rem_q != N_W'(1));

	// Row of cells: shift toward higher index, rotate toward lower index
	genvar k;
	generate
		for (k = 0; k < TAPS; k++) begin : g_cell
			logic signed [SAMPLE_BITS-1:0] prev_s;
			logic signed [COEF_W-1:0]      nxt_c;
			logic signed [SAMPLE_BITS-1:0] nxt_s;

			if (k == 0) begin : g_head
				assign prev_s = shift_data;
			end else begin : g_body
				assign prev_s = samp_w[k-1];
			end

			if (k == TAPS - 1) begin : g_tail
				assign nxt_c = coef_w[0];
				assign nxt_s = samp_w[0];
			end else begin : g_inner
				assign nxt_c = coef_w[k+1];
				assign nxt_s = samp_w[k+1];
			end

			flc_cell #(
				.SAMPLE_BITS(SAMPLE_BITS),
				.INDEX      (k)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.coef_idx (s_idx),
				.coef_in  (s_value),
				.samp_prev(prev_s),
				.coef_nxt (nxt_c),
				.samp_nxt (nxt_s),
				.coef     (coef_w[k]),
				.samp     (samp_w[k])
			);
		end
	endgenerate

	// Shared multiply-accumulate at the ring head
	flc_mac #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (mac_clr),
		.en    (mac_en),
		.coef  (coef_w[0]),
		.samp  (samp_w[0]),
		.acc   (acc)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (s_tuser == MODE_PUSH ||
						(s_tuser == MODE_FLUSH && !single_tap))) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = more_tail ? ST_RUN : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Controls for cells, accumulator and output register
	always_comb begin
		ctrl       = '0;
		s_tready   = 1'b0;
		shift_zero = 1'b0;
		mac_clr    = 1'b0;
		mac_en     = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					case (s_tuser)
						MODE_LOAD: begin
							ctrl.load = 1'b1;
						end
						MODE_PUSH: begin
							ctrl.shift = 1'b1;
							mac_clr    = 1'b1;
						end
						MODE_FLUSH: begin
							if (single_tap) begin
								ctrl.clear = 1'b1;
							end else begin
								ctrl.shift = 1'b1;
								shift_zero = 1'b1;
								mac_clr    = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_RUN: begin
				ctrl.rotate = 1'b1;
				mac_en      = N_W'(cnt_q) < n_act;
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					if (more_tail) begin
						ctrl.shift = 1'b1;
						shift_zero = 1'b1;
						mac_clr    = 1'b1;
					end else if (flush_q) begin
						ctrl.clear = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			flush_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (accept && s_tuser == MODE_PUSH) begin
				flush_q <= 1'b0;
			end else if (accept && s_tuser == MODE_FLUSH && !single_tap) begin
				flush_q <= 1'b1;
				rem_q   <= n_act - N_W'(1);
			end else if (out_load && flush_q) begin
				rem_q <= rem_q - N_W'(1);
			end
		end
	end

	// Hold the tap count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q <= NTAPS_RST;
		end else if (cfg_we) begin
			num_taps_q <= cfg_data;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= acc;
			m_last_q <= flush_q && (rem_q == N_W'(1));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'(m_data_q);
	assign m_tlast  = m_last_q;

	// A running flush always has tail results left
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && flush_q) |-> rem_q != '0)
		else $error("flush running with no tail results left");

	// Drain only ever follows the last rotation
	a_drain_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> $past(state_q) == ST_RUN)
		else $error("drain entered without a full ring pass");

	// A result is only written into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("result overwrote a pending beat");

	// The end of a flush leaves an empty history
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && flush_q && rem_q == N_W'(1)) |=> samp_w[0] == '0)
		else $error("history not cleared after flush");

endmodule
